// ===== hdl/thtr_pkg.sv =====
// ----------------------------------------------------------------------------
// thtr_pkg
// Shared types and constants for the two-wire humidity and temperature reader.
// ----------------------------------------------------------------------------
package thtr_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 12;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_SETTLE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POLL_LIMIT   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FAIL_THRESH  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HUM_POLL     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TMP_POLL     = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAP          = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HUM_CMD      = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TMP_CMD      = 3'd7;

   localparam logic [7:0]  RST_START_SETTLE = 8'd15;
   localparam logic [11:0] RST_POLL_LIMIT   = 12'd4000;
   localparam logic [11:0] RST_FAIL_THRESH  = 12'd3990;
   localparam logic [7:0]  RST_HUM_POLL     = 8'd2;
   localparam logic [7:0]  RST_TMP_POLL     = 8'd4;
   localparam logic [9:0]  RST_GAP          = 10'd100;
   localparam logic [7:0]  RST_HUM_CMD      = 8'b10100000;
   localparam logic [7:0]  RST_TMP_CMD      = 8'b11000000;

   localparam logic [15:0] FAIL_WORD = 16'hFFFF;

   localparam int unsigned FLAG_HACK  = 0;
   localparam int unsigned FLAG_TACK  = 1;
   localparam int unsigned FLAG_HFAIL = 2;
   localparam int unsigned FLAG_TFAIL = 3;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_BEGIN,
      PH_START,
      PH_CMD_LOW,
      PH_CMD_DATA,
      PH_CMD_HIGH,
      PH_ACK_LOW,
      PH_ACK_HIGH,
      PH_POLL,
      PH_READ_LOW,
      PH_READ_HIGH,
      PH_MACK_LOW,
      PH_MACK_HIGH,
      PH_FINISH
   } phase_type;

   typedef struct packed {
      logic start_request;
      logic data_in;
   } req_type;

   typedef struct packed {
      logic        clock_out;
      logic        data_out;
      logic        data_drive;
      logic        busy_res;
      logic        done_res;
      logic [15:0] humidity_word;
      logic [15:0] temperature_word;
      logic        humidity_ack;
      logic        temperature_ack;
      logic        humidity_failed;
      logic        temperature_failed;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  start_settle_ticks;
      logic [11:0] poll_limit;
      logic [11:0] fail_threshold;
      logic [7:0]  humidity_poll_ticks;
      logic [7:0]  temperature_poll_ticks;
      logic [9:0]  gap_ticks;
      logic [7:0]  humidity_command;
      logic [7:0]  temperature_command;
   } cfg_type;

endpackage

// ===== hdl/thtr_csr.sv =====
// ----------------------------------------------------------------------------
// thtr_csr
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module thtr_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [thtr_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [thtr_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output thtr_pkg::cfg_type                     cfg
);

   thtr_pkg::cfg_type cfg_ff;
   thtr_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            thtr_pkg::CSR_START_SETTLE: cfg_in.start_settle_ticks     = csr_wdata[7:0];
            thtr_pkg::CSR_POLL_LIMIT:   cfg_in.poll_limit             = csr_wdata[11:0];
            thtr_pkg::CSR_FAIL_THRESH:  cfg_in.fail_threshold         = csr_wdata[11:0];
            thtr_pkg::CSR_HUM_POLL:     cfg_in.humidity_poll_ticks    = csr_wdata[7:0];
            thtr_pkg::CSR_TMP_POLL:     cfg_in.temperature_poll_ticks = csr_wdata[7:0];
            thtr_pkg::CSR_GAP:          cfg_in.gap_ticks              = csr_wdata[9:0];
            thtr_pkg::CSR_HUM_CMD:      cfg_in.humidity_command       = csr_wdata[7:0];
            thtr_pkg::CSR_TMP_CMD:      cfg_in.temperature_command    = csr_wdata[7:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_settle_ticks     <= thtr_pkg::RST_START_SETTLE;
         cfg_ff.poll_limit             <= thtr_pkg::RST_POLL_LIMIT;
         cfg_ff.fail_threshold         <= thtr_pkg::RST_FAIL_THRESH;
         cfg_ff.humidity_poll_ticks    <= thtr_pkg::RST_HUM_POLL;
         cfg_ff.temperature_poll_ticks <= thtr_pkg::RST_TMP_POLL;
         cfg_ff.gap_ticks              <= thtr_pkg::RST_GAP;
         cfg_ff.humidity_command       <= thtr_pkg::RST_HUM_CMD;
         cfg_ff.temperature_command    <= thtr_pkg::RST_TMP_CMD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/thtr_seq.sv =====
// ----------------------------------------------------------------------------
// thtr_seq
// Tick sequencer: advances the bus protocol by one step per accepted word and
// presents the resulting pin levels and latched readings.
// ----------------------------------------------------------------------------
module thtr_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  thtr_pkg::req_type req,
   input  thtr_pkg::cfg_type cfg,
   output thtr_pkg::rsp_type rsp_next
);

   thtr_pkg::phase_type phase_ff, phase_in;
   logic [9:0]  tick_ff, tick_in;
   logic [3:0]  bit_ff, bit_in;
   logic [11:0] poll_ff, poll_in;
   logic [15:0] shift_ff, shift_in;
   logic        temp_ff, temp_in;
   logic [15:0] hum_hold_ff, hum_hold_in;
   logic [15:0] tmp_hold_ff, tmp_hold_in;
   logic [3:0]  flags_ff, flags_in;
   logic        clk_ff, clk_in;
   logic        dout_ff, dout_in;
   logic        drive_ff, drive_in;
   logic        done;

   logic [3:0]  bit_inc;
   logic [12:0] poll_inc;
   logic [7:0]  cmd;
   logic [7:0]  poll_ticks;
   logic [1:0]  fail_idx;
   logic [1:0]  ack_idx;
   logic        fail;
   logic [15:0] word;

   always_comb begin
      bit_inc    = bit_ff + 4'd1;
      poll_inc   = {1'b0, poll_ff} + 13'd1;
      cmd        = temp_ff ? cfg.temperature_command : cfg.humidity_command;
      poll_ticks = temp_ff ? cfg.temperature_poll_ticks : cfg.humidity_poll_ticks;
      fail_idx   = temp_ff ? 2'(thtr_pkg::FLAG_TFAIL) : 2'(thtr_pkg::FLAG_HFAIL);
      ack_idx    = temp_ff ? 2'(thtr_pkg::FLAG_TACK) : 2'(thtr_pkg::FLAG_HACK);
      fail       = req.data_in ? (poll_inc > {1'b0, cfg.fail_threshold})
                               : (poll_ff > cfg.fail_threshold);
      word       = flags_ff[fail_idx] ? thtr_pkg::FAIL_WORD : shift_ff;
   end

   always_comb begin
      phase_in    = phase_ff;
      tick_in     = tick_ff;
      bit_in      = bit_ff;
      poll_in     = poll_ff;
      shift_in    = shift_ff;
      temp_in     = temp_ff;
      hum_hold_in = hum_hold_ff;
      tmp_hold_in = tmp_hold_ff;
      flags_in    = flags_ff;
      clk_in      = clk_ff;
      dout_in     = dout_ff;
      drive_in    = drive_ff;
      done        = 1'b0;
      if (phase_ff == thtr_pkg::PH_IDLE) begin
         if (req.start_request) begin
            temp_in  = 1'b0;
            drive_in = 1'b1;
            dout_in  = 1'b1;
            tick_in  = (cfg.start_settle_ticks == 8'd0) ? 10'd0
                       : {2'b00, cfg.start_settle_ticks - 8'd1};
            phase_in = thtr_pkg::PH_START;
            bit_in   = 4'd0;
         end
      end else if (tick_ff != 10'd0) begin
         tick_in = tick_ff - 10'd1;
      end else begin
         unique case (phase_ff)
            thtr_pkg::PH_BEGIN: begin
               drive_in = 1'b1;
               dout_in  = 1'b1;
               tick_in  = (cfg.start_settle_ticks == 8'd0) ? 10'd0
                          : {2'b00, cfg.start_settle_ticks - 8'd1};
               phase_in = thtr_pkg::PH_START;
               bit_in   = 4'd0;
            end
            thtr_pkg::PH_START: begin
               case (bit_ff[2:0])
                  3'd0, 3'd3, 3'd6: clk_in  = 1'b0;
                  3'd1, 3'd4:       clk_in  = 1'b1;
                  3'd2, 3'd7:       dout_in = 1'b0;
                  default:          dout_in = 1'b1;
               endcase
               if (bit_ff >= 4'd7) begin
                  phase_in = thtr_pkg::PH_CMD_LOW;
                  bit_in   = 4'd0;
               end else begin
                  bit_in = bit_inc;
               end
            end
            thtr_pkg::PH_CMD_LOW: begin
               clk_in   = 1'b0;
               phase_in = thtr_pkg::PH_CMD_DATA;
            end
            thtr_pkg::PH_CMD_DATA: begin
               dout_in  = cmd[bit_ff[2:0]];
               phase_in = thtr_pkg::PH_CMD_HIGH;
            end
            thtr_pkg::PH_CMD_HIGH: begin
               clk_in = 1'b1;
               if (bit_inc >= 4'd8) begin
                  drive_in = 1'b0;
                  bit_in   = 4'd0;
                  phase_in = thtr_pkg::PH_ACK_LOW;
               end else begin
                  bit_in   = bit_inc;
                  phase_in = thtr_pkg::PH_CMD_LOW;
               end
            end
            thtr_pkg::PH_ACK_LOW: begin
               clk_in   = 1'b0;
               phase_in = thtr_pkg::PH_ACK_HIGH;
            end
            thtr_pkg::PH_ACK_HIGH: begin
               clk_in            = 1'b1;
               flags_in[ack_idx] = ~req.data_in;
               poll_in           = 12'd0;
               phase_in          = thtr_pkg::PH_POLL;
            end
            thtr_pkg::PH_POLL: begin
               clk_in = 1'b0;
               if (req.data_in && (poll_ff < cfg.poll_limit)) begin
                  poll_in = poll_inc[11:0];
                  tick_in = (poll_ticks == 8'd0) ? 10'd0 : {2'b00, poll_ticks - 8'd1};
               end else begin
                  flags_in[fail_idx] = fail;
                  bit_in             = 4'd0;
                  phase_in           = thtr_pkg::PH_READ_LOW;
               end
            end
            thtr_pkg::PH_READ_LOW: begin
               clk_in   = 1'b0;
               drive_in = 1'b0;
               phase_in = thtr_pkg::PH_READ_HIGH;
            end
            thtr_pkg::PH_READ_HIGH: begin
               clk_in   = 1'b1;
               shift_in = {shift_ff[14:0], req.data_in};
               bit_in   = bit_inc;
               phase_in = (bit_inc == 4'd8 || bit_inc == 4'd0) ? thtr_pkg::PH_MACK_LOW
                                                               : thtr_pkg::PH_READ_LOW;
            end
            thtr_pkg::PH_MACK_LOW: begin
               clk_in   = 1'b0;
               drive_in = 1'b1;
               dout_in  = (bit_ff == 4'd0);
               phase_in = thtr_pkg::PH_MACK_HIGH;
            end
            thtr_pkg::PH_MACK_HIGH: begin
               clk_in   = 1'b1;
               phase_in = (bit_ff == 4'd0) ? thtr_pkg::PH_FINISH : thtr_pkg::PH_READ_LOW;
            end
            thtr_pkg::PH_FINISH: begin
               clk_in   = 1'b0;
               drive_in = 1'b0;
               if (!temp_ff) begin
                  hum_hold_in = word;
                  temp_in     = 1'b1;
                  tick_in     = cfg.gap_ticks;
                  phase_in    = thtr_pkg::PH_BEGIN;
               end else begin
                  tmp_hold_in = word;
                  temp_in     = 1'b0;
                  done        = 1'b1;
                  phase_in    = thtr_pkg::PH_IDLE;
               end
            end
            default: phase_in = thtr_pkg::PH_IDLE;
         endcase
      end
   end

   always_comb begin
      rsp_next.clock_out          = clk_in;
      rsp_next.data_out           = drive_in & dout_in;
      rsp_next.data_drive         = drive_in;
      rsp_next.busy_res           = (phase_in != thtr_pkg::PH_IDLE);
      rsp_next.done_res           = done;
      rsp_next.humidity_word      = hum_hold_in;
      rsp_next.temperature_word   = tmp_hold_in;
      rsp_next.humidity_ack       = flags_in[thtr_pkg::FLAG_HACK];
      rsp_next.temperature_ack    = flags_in[thtr_pkg::FLAG_TACK];
      rsp_next.humidity_failed    = flags_in[thtr_pkg::FLAG_HFAIL];
      rsp_next.temperature_failed = flags_in[thtr_pkg::FLAG_TFAIL];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= thtr_pkg::PH_IDLE;
         tick_ff     <= 10'd0;
         bit_ff      <= 4'd0;
         poll_ff     <= 12'd0;
         shift_ff    <= 16'd0;
         temp_ff     <= 1'b0;
         hum_hold_ff <= 16'd0;
         tmp_hold_ff <= 16'd0;
         flags_ff    <= 4'd0;
         clk_ff      <= 1'b0;
         dout_ff     <= 1'b0;
         drive_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         tick_ff     <= tick_in;
         bit_ff      <= bit_in;
         poll_ff     <= poll_in;
         shift_ff    <= shift_in;
         temp_ff     <= temp_in;
         hum_hold_ff <= hum_hold_in;
         tmp_hold_ff <= tmp_hold_in;
         flags_ff    <= flags_in;
         clk_ff      <= clk_in;
         dout_ff     <= dout_in;
         drive_ff    <= drive_in;
      end
   end

endmodule

// ===== hdl/two_wire_humidity_temp_reader.sv =====
// ----------------------------------------------------------------------------
// two_wire_humidity_temp_reader
// Two-wire humidity and temperature sensor reader, one timing tick per word.
//
//   channel  ports                          direction  word
//   req      req_valid req_stall req_data   in         start request, data line
//   rsp      rsp_valid rsp_stall rsp_data   out        pins, status, readings
//   csr      csr_we csr_index csr_wdata     in         register write
//
// One word per cycle while req_stall is low; each accepted word moves the
// sequencer one tick, and its result sits in the output register in the
// next cycle. The output register parts the two sides; req_stall rises
// only while a result waits and rsp_stall is high.
// Reset is synchronous and clears the sequencer and loads register defaults.
// ----------------------------------------------------------------------------
module two_wire_humidity_temp_reader (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  thtr_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output thtr_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [thtr_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [thtr_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   thtr_pkg::cfg_type cfg;
   thtr_pkg::rsp_type rsp_next;
   thtr_pkg::rsp_type rsp_data_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              accept;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   thtr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   thtr_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .advance  (accept),
      .req      (req_data),
      .cfg      (cfg),
      .rsp_next (rsp_next)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-wire humidity and temperature reader.
// Each word sent is one timing tick. A cycle-accurate sequencer model inside
// the bench predicts the pin levels and latched readings for every tick. A
// sensor stand-in answers the ACK and conversion polls from the predicted
// state and drives random read bits. Register settings cover defaults, zero
// values, limits and random mixes. Both handshake sides idle at random, and
// the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

   logic                                 clock     = 1'b0;
   logic                                 reset     = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   thtr_pkg::req_type                    req_data  = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   thtr_pkg::rsp_type                    rsp_data;
   logic                                 csr_we    = 1'b0;
   logic [thtr_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [thtr_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   two_wire_humidity_temp_reader dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sequencer model state
   thtr_pkg::cfg_type   cfg;
   thtr_pkg::phase_type seq_phase;
   logic [9:0]          seq_ticks;
   logic [3:0]          seq_bits;
   logic [11:0]         seq_polls;
   logic [15:0]         seq_shift;
   logic                seq_temp;
   logic [15:0]         hum_hold;
   logic [15:0]         tmp_hold;
   logic [3:0]          seq_flags;
   logic                pin_clk;
   logic                pin_dout;
   logic                pin_drive;

   // sensor stand-in
   int unsigned ack_low_pct;
   int unsigned polls_lo [2];
   int unsigned polls_hi [2];
   int unsigned polls_left;

   thtr_pkg::rsp_type readout_q [$];
   thtr_pkg::rsp_type want_rsp;
   int unsigned mismatches = 0;
   int unsigned words_sent = 0;
   int unsigned burst_left = 0;
   int unsigned gap_max = 0;
   int unsigned stall_style = 0;
   int unsigned style_left = 0;
   event        hold_off_go;
   logic        holding = 1'b0;

   task automatic reset_sequencer();
      cfg = '{thtr_pkg::RST_START_SETTLE, thtr_pkg::RST_POLL_LIMIT,
              thtr_pkg::RST_FAIL_THRESH, thtr_pkg::RST_HUM_POLL,
              thtr_pkg::RST_TMP_POLL, thtr_pkg::RST_GAP,
              thtr_pkg::RST_HUM_CMD, thtr_pkg::RST_TMP_CMD};
      seq_phase = thtr_pkg::PH_IDLE;
      seq_ticks = '0;
      seq_bits  = '0;
      seq_polls = '0;
      seq_shift = '0;
      seq_temp  = 1'b0;
      hum_hold  = '0;
      tmp_hold  = '0;
      seq_flags = '0;
      pin_clk   = 1'b0;
      pin_dout  = 1'b0;
      pin_drive = 1'b0;
   endtask

   task automatic open_transfer();
      pin_drive = 1'b1;
      pin_dout  = 1'b1;
      seq_ticks = (cfg.start_settle_ticks != 8'd0) ? 10'(cfg.start_settle_ticks - 8'd1)
                                                   : 10'd0;
      seq_phase = thtr_pkg::PH_START;
      seq_bits  = '0;
   endtask

   task automatic advance_sequencer(input thtr_pkg::req_type w,
                                    output thtr_pkg::rsp_type r);
      logic        done;
      logic [7:0]  cmd;
      logic [7:0]  period;
      logic [15:0] word;
      int unsigned count;
      int unsigned fail_bit;
      done = 1'b0;
      fail_bit = seq_temp ? thtr_pkg::FLAG_TFAIL : thtr_pkg::FLAG_HFAIL;
      if (seq_phase == thtr_pkg::PH_IDLE) begin
         if (w.start_request) begin
            seq_temp = 1'b0;
            open_transfer();
         end
      end else if (seq_ticks != 0) begin
         seq_ticks--;
      end else begin
         case (seq_phase)
            thtr_pkg::PH_BEGIN: open_transfer();
            thtr_pkg::PH_START: begin
               case (seq_bits[2:0])
                  3'd0, 3'd3, 3'd6: pin_clk = 1'b0;
                  3'd1, 3'd4:       pin_clk = 1'b1;
                  3'd2, 3'd7:       pin_dout = 1'b0;
                  default:          pin_dout = 1'b1;
               endcase
               if (seq_bits >= 7) begin
                  seq_phase = thtr_pkg::PH_CMD_LOW;
                  seq_bits  = '0;
               end else begin
                  seq_bits++;
               end
            end
            thtr_pkg::PH_CMD_LOW: begin
               pin_clk   = 1'b0;
               seq_phase = thtr_pkg::PH_CMD_DATA;
            end
            thtr_pkg::PH_CMD_DATA: begin
               cmd       = seq_temp ? cfg.temperature_command : cfg.humidity_command;
               pin_dout  = cmd[seq_bits[2:0]];
               seq_phase = thtr_pkg::PH_CMD_HIGH;
            end
            thtr_pkg::PH_CMD_HIGH: begin
               pin_clk  = 1'b1;
               seq_bits = seq_bits + 1'b1;
               if (seq_bits >= 8) begin
                  pin_drive = 1'b0;
                  seq_bits  = '0;
                  seq_phase = thtr_pkg::PH_ACK_LOW;
               end else begin
                  seq_phase = thtr_pkg::PH_CMD_LOW;
               end
            end
            thtr_pkg::PH_ACK_LOW: begin
               pin_clk   = 1'b0;
               seq_phase = thtr_pkg::PH_ACK_HIGH;
            end
            thtr_pkg::PH_ACK_HIGH: begin
               pin_clk = 1'b1;
               seq_flags[seq_temp ? thtr_pkg::FLAG_TACK : thtr_pkg::FLAG_HACK] = !w.data_in;
               seq_polls = '0;
               seq_phase = thtr_pkg::PH_POLL;
            end
            thtr_pkg::PH_POLL: begin
               pin_clk = 1'b0;
               if (w.data_in && seq_polls < cfg.poll_limit) begin
                  seq_polls++;
                  period    = seq_temp ? cfg.temperature_poll_ticks : cfg.humidity_poll_ticks;
                  seq_ticks = (period != 8'd0) ? 10'(period - 8'd1) : 10'd0;
               end else begin
                  count = w.data_in ? seq_polls + 1 : seq_polls;
                  seq_flags[fail_bit] = (count > cfg.fail_threshold);
                  seq_bits  = '0;
                  seq_phase = thtr_pkg::PH_READ_LOW;
               end
            end
            thtr_pkg::PH_READ_LOW: begin
               pin_clk   = 1'b0;
               pin_drive = 1'b0;
               seq_phase = thtr_pkg::PH_READ_HIGH;
            end
            thtr_pkg::PH_READ_HIGH: begin
               pin_clk   = 1'b1;
               seq_shift = {seq_shift[14:0], w.data_in};
               seq_bits  = seq_bits + 1'b1;
               seq_phase = (seq_bits == 8 || seq_bits == 0) ? thtr_pkg::PH_MACK_LOW
                                                            : thtr_pkg::PH_READ_LOW;
            end
            thtr_pkg::PH_MACK_LOW: begin
               pin_clk   = 1'b0;
               pin_drive = 1'b1;
               pin_dout  = (seq_bits == 0);
               seq_phase = thtr_pkg::PH_MACK_HIGH;
            end
            thtr_pkg::PH_MACK_HIGH: begin
               pin_clk   = 1'b1;
               seq_phase = (seq_bits == 0) ? thtr_pkg::PH_FINISH : thtr_pkg::PH_READ_LOW;
            end
            thtr_pkg::PH_FINISH: begin
               pin_clk   = 1'b0;
               pin_drive = 1'b0;
               word = seq_flags[fail_bit] ? thtr_pkg::FAIL_WORD : seq_shift;
               if (!seq_temp) begin
                  hum_hold  = word;
                  seq_temp  = 1'b1;
                  seq_ticks = cfg.gap_ticks;
                  seq_phase = thtr_pkg::PH_BEGIN;
               end else begin
                  tmp_hold  = word;
                  seq_temp  = 1'b0;
                  done      = 1'b1;
                  seq_phase = thtr_pkg::PH_IDLE;
               end
            end
            default: seq_phase = thtr_pkg::PH_IDLE;
         endcase
      end
      r.clock_out          = pin_clk;
      r.data_out           = pin_drive & pin_dout;
      r.data_drive         = pin_drive;
      r.busy_res           = (seq_phase != thtr_pkg::PH_IDLE);
      r.done_res           = done;
      r.humidity_word      = hum_hold;
      r.temperature_word   = tmp_hold;
      r.humidity_ack       = seq_flags[thtr_pkg::FLAG_HACK];
      r.temperature_ack    = seq_flags[thtr_pkg::FLAG_TACK];
      r.humidity_failed    = seq_flags[thtr_pkg::FLAG_HFAIL];
      r.temperature_failed = seq_flags[thtr_pkg::FLAG_TFAIL];
   endtask

   // answer ACK and polls; random bits elsewhere, read bits included
   function automatic logic sensor_line();
      if (seq_phase == thtr_pkg::PH_ACK_HIGH && seq_ticks == 0) begin
         polls_left = $urandom_range(polls_lo[seq_temp], polls_hi[seq_temp]);
         return ($urandom_range(0, 99) >= ack_low_pct);
      end
      if (seq_phase == thtr_pkg::PH_POLL && seq_ticks == 0) begin
         if (polls_left == 0)
            return 1'b0;
         polls_left--;
         return 1'b1;
      end
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic set_sensor(input int unsigned ack_pct, input int unsigned hum_lo,
                             input int unsigned hum_hi, input int unsigned tmp_lo,
                             input int unsigned tmp_hi);
      ack_low_pct = ack_pct;
      polls_lo[0] = hum_lo;
      polls_hi[0] = hum_hi;
      polls_lo[1] = tmp_lo;
      polls_hi[1] = tmp_hi;
   endtask

   task automatic send_word(input logic start);
      thtr_pkg::req_type w;
      thtr_pkg::rsp_type r;
      int unsigned       gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      w.start_request = start;
      w.data_in       = sensor_line();
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      words_sent++;
      advance_sequencer(w, r);
      readout_q.push_back(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (readout_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [thtr_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [thtr_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_config(input thtr_pkg::cfg_type c);
      drain();
      write_csr(thtr_pkg::CSR_START_SETTLE, 12'(c.start_settle_ticks));
      write_csr(thtr_pkg::CSR_POLL_LIMIT, c.poll_limit);
      write_csr(thtr_pkg::CSR_FAIL_THRESH, c.fail_threshold);
      write_csr(thtr_pkg::CSR_HUM_POLL, 12'(c.humidity_poll_ticks));
      write_csr(thtr_pkg::CSR_TMP_POLL, 12'(c.temperature_poll_ticks));
      write_csr(thtr_pkg::CSR_GAP, 12'(c.gap_ticks));
      write_csr(thtr_pkg::CSR_HUM_CMD, 12'(c.humidity_command));
      write_csr(thtr_pkg::CSR_TMP_CMD, 12'(c.temperature_command));
      csr_we <= 1'b0;
      cfg = c;
   endtask

   task automatic run_measurement();
      send_word(1'b1);
      while (seq_phase != thtr_pkg::PH_IDLE) send_word(1'($urandom_range(0, 1)));
   endtask

   task automatic test_idle_outputs();
      gap_max = 2;
      repeat (4) send_word(1'b0);
   endtask

   task automatic test_default_cycle();
      gap_max = 3;
      set_sensor(100, 1, 3, 0, 2);
      run_measurement();
   endtask

   task automatic test_zero_settings();
      load_config('{8'd0, 12'd0, 12'd0, 8'd0, 8'd0, 10'd0, 8'h00, 8'hFF});
      set_sensor(0, 1, 1, 0, 0);
      run_measurement();
   endtask

   task automatic test_poll_threshold();
      load_config('{8'd2, 12'd10, 12'd3, 8'd1, 8'd1, 10'd0,
                    thtr_pkg::RST_HUM_CMD, thtr_pkg::RST_TMP_CMD});
      set_sensor(100, 3, 3, 4, 4);
      run_measurement();
      load_config('{8'd1, 12'd3, 12'd3, 8'd2, 8'd1, 10'd1, 8'h5A, 8'hA5});
      set_sensor(100, 10, 10, 3, 3);
      run_measurement();
      load_config('{8'd1, 12'd4095, 12'd4095, 8'd0, 8'd1, 10'd0, 8'h0F, 8'hF0});
      set_sensor(50, 5000, 5000, 0, 0);
      run_measurement();
   endtask

   task automatic test_extremes();
      load_config('{8'd255, 12'd4095, 12'd0, 8'd255, 8'd255, 10'd1023, 8'h55, 8'hAA});
      set_sensor(100, 2, 2, 1, 1);
      run_measurement();
   endtask

   task automatic test_backpressure();
      load_config('{8'd1, 12'd20, 12'd10, 8'd1, 8'd1, 10'd2, 8'h3C, 8'h81});
      set_sensor(80, 0, 4, 0, 4);
      gap_max = 0;
      -> hold_off_go;
      run_measurement();
   endtask

   task automatic test_random();
      thtr_pkg::cfg_type c;
      int unsigned       first;
      first = words_sent;
      while (words_sent - first < 600) begin
         c.start_settle_ticks = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                               : $urandom_range(0, 4));
         c.poll_limit = 12'($urandom_range(0, 1) ? $urandom_range(0, 12)
                                                 : $urandom_range(0, 4095));
         c.fail_threshold = 12'($urandom_range(0, 1) ? $urandom_range(0, 14)
                                                     : $urandom_range(0, 4095));
         c.humidity_poll_ticks    = 8'($urandom_range(0, 3));
         c.temperature_poll_ticks = 8'($urandom_range(0, 3));
         c.gap_ticks = 10'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023)
                                                       : $urandom_range(0, 8));
         c.humidity_command    = 8'($urandom_range(0, 255));
         c.temperature_command = 8'($urandom_range(0, 255));
         load_config(c);
         if (c.poll_limit <= 12)
            set_sensor(85, 0, c.poll_limit + 2, 0, c.poll_limit + 2);
         else
            set_sensor(85, 0, 6, 0, 6);
         gap_max = $urandom_range(0, 6);
         repeat ($urandom_range(0, 4)) send_word(1'b0);
         run_measurement();
      end
   endtask

   function automatic string rsp_text(input thtr_pkg::rsp_type x);
      return $sformatf("clk=%b dout=%b drv=%b busy=%b done=%b hum=%h tmp=%h ack=%b%b fail=%b%b",
                       x.clock_out, x.data_out, x.data_drive, x.busy_res, x.done_res,
                       x.humidity_word, x.temperature_word, x.humidity_ack,
                       x.temperature_ack, x.humidity_failed, x.temperature_failed);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (readout_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp word: %s", rsp_text(rsp_data));
         end else begin
            want_rsp = readout_q.pop_front();
            if (rsp_data !== want_rsp) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("rsp mismatch at %0t", $realtime);
                  $display("  expected %s", rsp_text(want_rsp));
                  $display("  actual   %s", rsp_text(rsp_data));
               end
            end
         end
      end
   end

   // hold the receiver off for a long stretch on request
   initial begin
      forever begin
         @(hold_off_go);
         holding <= 1'b1;
         repeat (120) @(posedge clock);
         holding <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (style_left == 0) begin
         style_left  = $urandom_range(20, 200);
         stall_style = $urandom_range(0, 3);
      end
      style_left--;
      if (holding) begin
         rsp_stall <= 1'b1;
      end else begin
         case (stall_style)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= 1'($urandom_range(0, 1));
            default: rsp_stall <= (style_left % 3 == 0);
         endcase
      end
   end

   initial begin
      reset_sequencer();
      set_sensor(100, 0, 0, 0, 0);
      polls_left = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_idle_outputs();
      test_default_cycle();
      test_zero_settings();
      test_poll_threshold();
      test_extremes();
      test_backpressure();
      test_random();
      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/thtr_pkg.sv
hdl/thtr_csr.sv
hdl/thtr_seq.sv
hdl/two_wire_humidity_temp_reader.sv
tb/sv/tb_top.sv
